@@ sv/mrlx_pkg.sv @@
`default_nettype none
package mrlx_pkg;
    localparam int unsigned VAL_W = 31;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned REM_W = 62;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_MULT  = 3'd1;
    localparam logic [2:0] REG_INC   = 3'd2;
    localparam logic [2:0] REG_MOD   = 3'd3;
    localparam logic [2:0] REG_ROUNDS = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRV_WR,
        ST_DRV_MUL,
        ST_DRV_DIV,
        ST_DRV_STEP,
        ST_RUN_RD,
        ST_RUN_LOAD,
        ST_RUN_MUL,
        ST_RUN_DIV,
        ST_RUN_WR,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

@@ sv/multi_round_lcg_xor_cipher_top.sv @@
// n = round_count clamped to 1..MAX_ROUNDS rounds run per word; a round is read, load,
//   multiply, 62-step remainder and write back
// a word flagged first first derives every round from the configuration registers
// one word in flight: no new word is taken until its result has been handed over; a round
//   with zero modulus skips the remainder (and the trial steps while deriving)
// reset: rst_n asynchronous active low; round memory reads as zero until a word flagged first
`default_nettype none
module multi_round_lcg_xor_cipher_top
    import mrlx_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             first_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            result_byte,
    output logic                  error,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [VAL_W-1:0] cfg_data
);
    localparam int unsigned RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
    localparam int unsigned NW = RW + 1;
    localparam int unsigned DW = 4 * VAL_W;
    localparam int unsigned BW = 6;

    // configuration registers
    logic [VAL_W-1:0] start_reg, mult_reg, inc_reg, mod_reg;
    logic [CNT_W-1:0] rounds_reg;

    // sequencer registers
    state_t           state_reg, state_next;
    logic [RW-1:0]    round_reg;
    logic [1:0]       step_reg;
    logic [VAL_W-1:0] x_reg, m_reg, c_reg, md_reg;
    logic [VAL_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [REM_W-1:0] prod_reg;
    logic [VAL_W-1:0] rem_reg;
    logic [BW-1:0]    bit_reg;
    logic [7:0]       data_reg;
    logic             err_reg;
    logic             loaded_reg;

    // round memory: {state, mult, inc, mod} per round, one read and one write port
    logic [DW-1:0]    rmem [MAX_ROUNDS];
    logic [DW-1:0]    rd_data;
    logic             rd_en;
    logic             wr_en;
    logic [DW-1:0]    wr_data;
    logic [DW-1:0]    mem_word;

    logic [NW-1:0]    nrounds;
    logic             last_round;
    logic             last_run;
    logic [VAL_W:0]   rem_shift;
    logic [VAL_W+1:0] trial;
    logic [VAL_W-1:0] rem_next;
    logic [REM_W-1:0] prod_next;

    // registers only change while the sequencer is idle and no word is offered,
    // so the word being accepted always sees the settings it was sent with
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 31'd20011;
            mult_reg   <= 31'd10007;
            inc_reg    <= 31'd100003;
            mod_reg    <= 31'd2147483647;
            rounds_reg <= 4'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START:  start_reg  <= cfg_data;
                REG_MULT:   mult_reg   <= cfg_data;
                REG_INC:    inc_reg    <= cfg_data;
                REG_MOD:    mod_reg    <= cfg_data;
                REG_ROUNDS: rounds_reg <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rmem[round_reg] <= wr_data;
        if (rd_en)
            rd_data <= rmem[round_reg];
    end

    // entries read as zero until the first derive has filled every round
    assign mem_word = loaded_reg ? rd_data : '0;

    // active rounds: zero counts as one, anything above MAX_ROUNDS saturates
    always_comb
    begin
        if (rounds_reg == '0)
            nrounds = NW'(1);
        else if (32'(rounds_reg) > MAX_ROUNDS)
            nrounds = NW'(MAX_ROUNDS);
        else
            nrounds = NW'(rounds_reg);
    end

    assign last_round = (round_reg == RW'(MAX_ROUNDS - 1));
    assign last_run   = ((NW'(round_reg) + NW'(1)) == nrounds);

    // generator product, below 2^62 for 31-bit operands
    assign prod_next = {{VAL_W{1'b0}}, x_reg} * {{VAL_W{1'b0}}, m_reg}
                     + {{VAL_W{1'b0}}, c_reg};

    // one restoring remainder step over the 62-bit dividend, msb first;
    // the partial remainder stays below the modulus so 31 bits hold it
    assign rem_shift = {rem_reg, prod_reg[REM_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, md_reg};
    assign rem_next  = trial[VAL_W+1] ? rem_shift[VAL_W-1:0] : trial[VAL_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = first_byte ? ST_DRV_WR : ST_RUN_RD;
            // write the round, then four trial steps seed the next one (a zero modulus skips them)
            ST_DRV_WR:
                if (last_round)
                    state_next = ST_RUN_RD;
                else if (md_reg == '0)
                    state_next = ST_DRV_WR;
                else
                    state_next = ST_DRV_MUL;
            ST_DRV_MUL: state_next = ST_DRV_DIV;
            ST_DRV_DIV:
                if (bit_reg == '0)
                    state_next = ST_DRV_STEP;
            ST_DRV_STEP:
                state_next = (step_reg == 2'd3) ? ST_DRV_WR : ST_DRV_MUL;
            ST_RUN_RD:   state_next = ST_RUN_LOAD;
            ST_RUN_LOAD: state_next = ST_RUN_MUL;
            // a zero modulus skips the remainder and holds the round's state
            ST_RUN_MUL:
                state_next = (md_reg == '0) ? ST_RUN_WR : ST_RUN_DIV;
            ST_RUN_DIV:
                if (bit_reg == '0)
                    state_next = ST_RUN_WR;
            ST_RUN_WR:
                state_next = last_run ? ST_OUT : ST_RUN_RD;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_data   = {x_reg, m_reg, c_reg, md_reg};
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_OUT:    out_valid = 1'b1;
            ST_RUN_RD: rd_en = 1'b1;
            ST_DRV_WR: wr_en = 1'b1;
            ST_RUN_WR:
            begin
                // write back the advanced state with the same parameters
                wr_en   = (md_reg != '0);
                wr_data = {rem_reg, m_reg, c_reg, md_reg};
            end
            default: ;
        endcase
    end
    assign result_byte = err_reg ? 8'd0 : data_reg;
    assign error       = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            step_reg   <= '0;
            x_reg      <= '0;
            m_reg      <= '0;
            c_reg      <= '0;
            md_reg     <= '0;
            p0_reg     <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
            prod_reg   <= '0;
            rem_reg    <= '0;
            bit_reg    <= '0;
            data_reg   <= '0;
            err_reg    <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        data_reg  <= data_byte;
                        err_reg   <= 1'b0;
                        round_reg <= '0;
                        // for a word flagged first, round one comes straight from configuration
                        x_reg  <= start_reg;
                        m_reg  <= mult_reg;
                        c_reg  <= inc_reg;
                        md_reg <= mod_reg;
                    end
                ST_DRV_WR:
                begin
                    loaded_reg <= 1'b1;
                    step_reg   <= '0;
                    if (last_round)
                        round_reg <= '0;
                    else
                    begin
                        round_reg <= round_reg + RW'(1);
                        // zero modulus hands zero parameters to the next round
                        if (md_reg == '0)
                        begin
                            x_reg <= '0;
                            m_reg <= '0;
                            c_reg <= '0;
                        end
                    end
                end
                ST_DRV_MUL, ST_RUN_MUL:
                begin
                    prod_reg <= prod_next;
                    rem_reg  <= '0;
                    bit_reg  <= BW'(REM_W - 1);
                    if (state_reg == ST_RUN_MUL && md_reg == '0)
                        err_reg <= 1'b1;
                end
                ST_DRV_DIV, ST_RUN_DIV:
                begin
                    prod_reg <= {prod_reg[REM_W-2:0], 1'b0};
                    rem_reg  <= rem_next;
                    bit_reg  <= bit_reg - BW'(1);
                end
                ST_DRV_STEP:
                begin
                    // trial outputs become state, mult, inc and mod of the next round
                    step_reg <= step_reg + 2'd1;
                    unique case (step_reg)
                        2'd0:
                        begin
                            p0_reg <= rem_reg;
                            x_reg  <= rem_reg;
                        end
                        2'd1:
                        begin
                            p1_reg <= rem_reg;
                            x_reg  <= rem_reg;
                        end
                        2'd2:
                        begin
                            p2_reg <= rem_reg;
                            x_reg  <= rem_reg;
                        end
                        default:
                        begin
                            x_reg  <= p0_reg;
                            m_reg  <= p1_reg;
                            c_reg  <= p2_reg;
                            md_reg <= rem_reg;
                        end
                    endcase
                end
                ST_RUN_LOAD:
                    {x_reg, m_reg, c_reg, md_reg} <= mem_word;
                ST_RUN_WR:
                begin
                    if (md_reg != '0)
                        data_reg <= data_reg ^ rem_reg[7:0];
                    round_reg <= round_reg + RW'(1);
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a second word while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (result_byte == 8'd0))
        else $error("error word carries data");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_byte) && $stable(error)))
        else $error("output word changed while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while a result waits");
endmodule
`default_nettype wire

@@ dv/mrlx_checker.sv @@
`default_nettype none
module mrlx_checker
    import mrlx_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = 8
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             first_byte,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic [7:0]       result_byte,
    input  wire logic             error,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [VAL_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    words_out
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       error;
    } cipher_word_t;

    logic [VAL_W-1:0] seed_reg, mult_reg, inc_reg, mod_reg;
    logic [CNT_W-1:0] rounds_reg;
    logic [VAL_W-1:0] gen_x [MAX_ROUNDS];
    logic [VAL_W-1:0] gen_m [MAX_ROUNDS];
    logic [VAL_W-1:0] gen_c [MAX_ROUNDS];
    logic [VAL_W-1:0] gen_md [MAX_ROUNDS];
    cipher_word_t expected_words[$];

    function automatic logic [VAL_W-1:0] lcg_step(logic [VAL_W-1:0] x, logic [VAL_W-1:0] m,
                                                  logic [VAL_W-1:0] c, logic [VAL_W-1:0] md);
        logic [63:0] v;
        v = 64'(x) * 64'(m) + 64'(c);
        return VAL_W'(v % 64'(md));
    endfunction

    // rebuild every round from the registers, each one seeding the next
    task automatic reload_rounds();
        logic [VAL_W-1:0] p [4];
        logic [VAL_W-1:0] t;
        p[0] = seed_reg; p[1] = mult_reg; p[2] = inc_reg; p[3] = mod_reg;
        for (int r = 0; r < MAX_ROUNDS; r++) begin
            gen_x[r] = p[0]; gen_m[r] = p[1]; gen_c[r] = p[2]; gen_md[r] = p[3];
            if (gen_md[r] != '0) begin
                t = gen_x[r];
                for (int k = 0; k < 4; k++) begin
                    t = lcg_step(t, gen_m[r], gen_c[r], gen_md[r]);
                    p[k] = t;
                end
            end
            else begin
                p[0] = '0; p[1] = '0; p[2] = '0; p[3] = '0;
            end
        end
    endtask

    task automatic cipher_byte(logic [7:0] d, logic f);
        int n;
        logic bad;
        cipher_word_t w;
        bad = 1'b0;
        if (f)
            reload_rounds();
        n = int'(rounds_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_ROUNDS)
            n = int'(MAX_ROUNDS);
        for (int r = 0; r < n; r++) begin
            if (gen_md[r] == '0)
                bad = 1'b1;
            else begin
                gen_x[r] = lcg_step(gen_x[r], gen_m[r], gen_c[r], gen_md[r]);
                d ^= gen_x[r][7:0];
            end
        end
        w.result_byte = bad ? 8'd0 : d;
        w.error = bad;
        expected_words = {expected_words, w};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_word_t e;
        if (!rst_n) begin
            seed_reg = 31'd20011; mult_reg = 31'd10007; inc_reg = 31'd100003;
            mod_reg = 31'h7FFFFFFF; rounds_reg = 4'd4;
            for (int r = 0; r < MAX_ROUNDS; r++) begin
                gen_x[r] = '0; gen_m[r] = '0; gen_c[r] = '0; gen_md[r] = '0;
            end
            expected_words.delete();
            fail_count = 0;
            words_out = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START:  seed_reg = cfg_data;
                    REG_MULT:   mult_reg = cfg_data;
                    REG_INC:    inc_reg = cfg_data;
                    REG_MOD:    mod_reg = cfg_data;
                    REG_ROUNDS: rounds_reg = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                cipher_byte(data_byte, first_byte);
            if (out_valid && out_ready) begin
                words_out++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word: result_byte %0h error %0b", result_byte, error);
                    fail_count++;
                end
                else begin
                    e = expected_words.pop_front();
                    if (result_byte !== e.result_byte) begin
                        $error("result_byte expected %0h actual %0h", e.result_byte,
                               result_byte);
                        fail_count++;
                    end
                    if (error !== e.error) begin
                        $error("error expected %0b actual %0b", e.error, error);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_words.size();
    end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
    import mrlx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXR = 8;
    localparam int NUM_WORDS = 2000;
    localparam int LIMIT = 25_000_000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic [7:0] data_byte = 0;
    logic first_byte = 0;
    logic out_ready = 0;
    logic cfg_valid = 0;
    logic [2:0] cfg_index = REG_START;
    logic [VAL_W-1:0] cfg_data = 0;
    logic in_ready, out_valid, error, cfg_ready;
    logic [7:0] result_byte;
    int fail_count, pending, words_out;
    int cycles = 0;
    // receiver hold-off requested by the stimulus process
    int hold_off = 0;
    int phases = 0;

    always #2 clk = ~clk;

    multi_round_lcg_xor_cipher_top #(.MAX_ROUNDS(MAXR)) dut (.*);

    mrlx_checker #(.MAX_ROUNDS(MAXR)) chk (.*);

    // timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: random stalls per word, plus a long hold-off when asked
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_off > 0) begin
                out_ready <= 0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [VAL_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // one word, with a random gap in front when gaps are on
    task automatic send_word(logic [7:0] d, logic f, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        data_byte <= d;
        first_byte <= f;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // every word gets a result, so an empty queue means the block is idle
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // random image: first word flagged, then mostly plain words, some flagged at random
    task automatic send_image(int len, bit gaps);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 40) == 0, gaps);
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFFFFFF;
            2: return VAL_W'($urandom_range(1, 100000));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: words before any first word give error
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        // reset settings, byte extremes, round count edges
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
        drain();
        write_reg(REG_ROUNDS, 31'd0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h3C, 1'b1, 1'b0);
        drain();
        write_reg(REG_ROUNDS, 31'd15);
        send_word(8'hC3, 1'b0, 1'b0);
        send_word(8'h81, 1'b1, 1'b0);
        drain();
        // zero modulus in round one
        write_reg(REG_MOD, 31'd0);
        write_reg(REG_ROUNDS, 31'd8);
        send_word(8'h12, 1'b1, 1'b0);
        send_word(8'h34, 1'b0, 1'b0);
        drain();
        // tiny modulus: later rounds collapse to zero parameters
        write_reg(REG_MOD, 31'd1);
        send_word(8'h77, 1'b1, 1'b0);
        drain();
        write_reg(REG_START, 31'h7FFFFFFF);
        write_reg(REG_MULT, 31'h7FFFFFFF);
        write_reg(REG_INC, 31'h7FFFFFFF);
        write_reg(REG_MOD, 31'h7FFFFFFE);
        write_reg(REG_ROUNDS, 31'd1);
        send_word(8'hEE, 1'b1, 1'b0);
        send_word(8'h11, 1'b0, 1'b0);
        drain();

        // long receiver hold-off while words keep coming
        write_reg(REG_ROUNDS, 31'd2);
        hold_off = 400;
        send_image(12, 1'b0);
        drain();

        // random phases with new settings between them
        sent = 0;
        while (sent < NUM_WORDS) begin
            int len;
            write_reg(REG_START, rand_val());
            write_reg(REG_MULT, rand_val());
            write_reg(REG_INC, rand_val());
            write_reg(REG_MOD, ($urandom_range(0, 9) == 0) ? 31'd0 : rand_val());
            write_reg(REG_ROUNDS, VAL_W'($urandom_range(0, 15)));
            len = $urandom_range(20, 120);
            send_image(len, $urandom_range(0, 3) != 0);
            sent += len;
            phases++;
            drain();
        end

        drain();
        $display("covered %0d settings phases, %0d words checked, extremes of round count",
                 phases, words_out);
        $display("and modulus, zero modulus and words before the first image word");
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
